@@ hw/rtl/mkd_pkg.sv @@
// ----------------------------------------------------------------------------
// mkd_pkg
// shared types and constants of the multi-key debounce controller
// ----------------------------------------------------------------------------
package mkd_pkg;

	typedef enum logic [1:0] {
		CMD_EDGE    = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_SUSPEND = 2'd2,
		CMD_START   = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd0;
	localparam logic [2:0] REG_ACTIVE_LOW     = 3'd1;
	localparam logic [2:0] REG_NOISE_IGNORE   = 3'd2;
	localparam logic [2:0] REG_MISSING_PAIR   = 3'd3;
	localparam logic [2:0] REG_REBOOT         = 3'd4;
	localparam logic [2:0] REG_REBOOT_EDGE    = 3'd5;
	localparam logic [2:0] REG_CONSOLE        = 3'd6;

	localparam int RES_CNT_W = 5;
	localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 5'd16;

	typedef struct packed {
		logic tick;
		logic clear;
		logic load;
	} lane_ctl_t;

	typedef struct packed {
		logic [2:0] key_button;
		logic       key_pressed;
		logic       reboot_notify;
		logic       reboot_level;
		logic       console_notify;
		logic       console_level;
	} key_event_t;

endpackage

@@ hw/rtl/multi_key_debounce_controller_top.sv @@
// ----------------------------------------------------------------------------
// multi_key_debounce_controller_top
// debounces up to BUTTONS key lines with one countdown lane per button
// ----------------------------------------------------------------------------
// edge and suspend beats are taken while idle and leave the block idle; a wake edge
//   pushes its event into the holding stage and moves on to the flush state
// a tick or start beat is taken, then the button walker, which shares one trigger unit,
//   visits every button (a paired event adds a step) and flushes; no new beat is taken
//   until the flush is done, and a stalled result bus holds the walk
// reset: all levels, countdowns and flags clear, registers take their defaults
// ----------------------------------------------------------------------------
module multi_key_debounce_controller_top #(
	parameter int BUTTONS     = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // button_index[2:0], pin_levels[10:3], wake_cause[11]
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // key_button[2:0], key_pressed, reboot_notify,
	                               // reboot_level, console_notify, console_level
	output logic        m_tlast,   // is_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mkd_pkg::*;

	localparam int CW = $clog2(BUTTONS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_t;

	// configuration
	logic [15:0] debounce_q;
	logic [7:0]  active_low_q, noise_ignore_q, missing_pair_q;
	logic [7:0]  reboot_q, reboot_edge_q, console_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= 16'd5;
			active_low_q   <= '0;
			noise_ignore_q <= '0;
			missing_pair_q <= '0;
			reboot_q       <= '0;
			reboot_edge_q  <= '0;
			console_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE_TICKS: debounce_q     <= cfg_data;
				REG_ACTIVE_LOW:     active_low_q   <= cfg_data[7:0];
				REG_NOISE_IGNORE:   noise_ignore_q <= cfg_data[7:0];
				REG_MISSING_PAIR:   missing_pair_q <= cfg_data[7:0];
				REG_REBOOT:         reboot_q       <= cfg_data[7:0];
				REG_REBOOT_EDGE:    reboot_edge_q  <= cfg_data[7:0];
				REG_CONSOLE:        console_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// widened masks and levels
	logic [31:0] pins32, alm32, nim32, mpm32, rbm32, rbe32, cnm32, ticks32;
	logic [BUTTONS-1:0] pressed_b, nim_b, mpm_b, rbm_b, rbe_b, cnm_b;
	logic [COUNT_WIDTH-1:0] reload_raw, reload;

	assign pins32  = {24'd0, s_tdata[10:3]};
	assign alm32   = {24'd0, active_low_q};
	assign nim32   = {24'd0, noise_ignore_q};
	assign mpm32   = {24'd0, missing_pair_q};
	assign rbm32   = {24'd0, reboot_q};
	assign rbe32   = {24'd0, reboot_edge_q};
	assign cnm32   = {24'd0, console_q};
	assign ticks32 = {16'd0, debounce_q};

	assign pressed_b = pins32[BUTTONS-1:0] ^ alm32[BUTTONS-1:0];
	assign nim_b     = nim32[BUTTONS-1:0];
	assign mpm_b     = mpm32[BUTTONS-1:0];
	assign rbm_b     = rbm32[BUTTONS-1:0];
	assign rbe_b     = rbe32[BUTTONS-1:0];
	assign cnm_b     = cnm32[BUTTONS-1:0];

	assign reload_raw = ticks32[COUNT_WIDTH-1:0];
	assign reload     = (reload_raw == '0) ? COUNT_WIDTH'(1) : reload_raw;

	// state
	state_t             state_q;
	logic [CW-1:0]      walk_q;
	logic               pair_q;
	logic               start_mode_q;
	logic [BUTTONS-1:0] settled_q, prev_q;
	logic [BUTTONS-1:0] old_s1, settle_s1;
	logic               wake_q, reb_rep_q, con_rep_q;

	// input beat decode
	cmd_t               cmd;
	logic               accept;
	logic [2:0]         idx;
	logic               wake;
	logic [BUTTONS-1:0] sel;
	logic               idx_ok, lvl_i, prev_i, set_i, pend_i, wake_path;
	logic               is_edge, is_tick, is_suspend, is_start;
	logic [BUTTONS-1:0] pending_b, restart_b, settle_b;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign idx      = s_tdata[2:0];
	assign wake     = s_tdata[11];

	always_comb begin
		is_edge    = 1'b0;
		is_tick    = 1'b0;
		is_suspend = 1'b0;
		is_start   = 1'b0;
		unique case (cmd)
			CMD_EDGE:    is_edge    = 1'b1;
			CMD_TICK:    is_tick    = 1'b1;
			CMD_SUSPEND: is_suspend = 1'b1;
			CMD_START:   is_start   = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		for (int k = 0; k < BUTTONS; k++) begin
			sel[k] = ({29'd0, idx} == 32'(k));
		end
	end

	assign idx_ok    = |sel;
	assign lvl_i     = |(pressed_b & sel);
	assign prev_i    = |(prev_q & sel);
	assign set_i     = |(settled_q & sel);
	assign pend_i    = |(pending_b & sel);
	assign wake_path = wake && wake_q;

	// lanes
	for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
		lane_ctl_t ctl;
		assign ctl.tick  = accept && is_tick;
		assign ctl.clear = accept && is_start;
		assign ctl.load  = accept && is_edge && sel[g]
			&& (!wake_path || (prev_q[g] == pressed_b[g]));
		mkd_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.reload  (reload),
			.level   (pressed_b[g]),
			.settled (settled_q[g]),
			.pending (pending_b[g]),
			.restart (restart_b[g]),
			.settle  (settle_b[g])
		);
	end

	// merging walker
	logic [BUTTONS-1:0] wsel, lowmask, work, rterm;
	logic               ws, wp, wset, same, ign, pairm;
	logic               reboot_v, console_v, rn, cn;
	logic [31:0]        walk32;
	logic               em_ready;
	logic               walk_push, walk_adv, walk_pair, walk_report;
	key_event_t         walk_ev, ev;
	logic               push;

	always_comb begin
		for (int k = 0; k < BUTTONS; k++) begin
			wsel[k]    = (walk_q == CW'(k));
			lowmask[k] = (CW'(k) < walk_q);
		end
	end

	assign ws    = |(settled_q & wsel);
	assign wp    = |(prev_q & wsel);
	assign wset  = |(settle_s1 & wsel);
	assign ign   = |(nim_b & wsel);
	assign pairm = |(mpm_b & wsel);
	assign same  = (ws == wp);

	assign work      = (settled_q & lowmask) | (old_s1 & ~lowmask);
	assign rterm     = (rbe_b & (work ^ prev_q)) | (~rbe_b & work);
	assign reboot_v  = &(~rbm_b | rterm);
	assign console_v = &(~cnm_b | work);
	assign rn        = reboot_v || (reb_rep_q != reboot_v);
	assign cn        = (con_rep_q != console_v);
	assign walk32    = 32'(walk_q);

	always_comb begin
		walk_push   = 1'b0;
		walk_adv    = 1'b0;
		walk_pair   = 1'b0;
		walk_report = 1'b0;
		walk_ev     = '{key_button: walk32[2:0], key_pressed: ws, default: 1'b0};
		if (state_q == ST_WALK && em_ready) begin
			priority if (start_mode_q) begin
				walk_push = 1'b1;
				walk_adv  = 1'b1;
			end else if (!wset || (same && ign)) begin
				walk_adv = 1'b1;
			end else if (same && pairm && !pair_q) begin
				walk_push               = 1'b1;
				walk_pair               = 1'b1;
				walk_ev.key_pressed     = !ws;
			end else begin
				walk_push              = 1'b1;
				walk_adv               = 1'b1;
				walk_report            = 1'b1;
				walk_ev.reboot_notify  = rn;
				walk_ev.reboot_level   = reboot_v;
				walk_ev.console_notify = cn;
				walk_ev.console_level  = console_v;
			end
		end
	end

	// wake edge event goes into an empty holding stage
	always_comb begin
		push = walk_push;
		ev   = walk_ev;
		if (accept && is_edge && idx_ok && wake_path) begin
			push = 1'b1;
			ev   = '{key_button: idx, key_pressed: !prev_i, default: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			walk_q       <= '0;
			pair_q       <= 1'b0;
			start_mode_q <= 1'b0;
			settled_q    <= '0;
			prev_q       <= '0;
			old_s1       <= '0;
			settle_s1    <= '0;
			wake_q       <= 1'b0;
			reb_rep_q    <= 1'b0;
			con_rep_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_edge && idx_ok) begin
							if (wake_path) begin
								settled_q <= (settled_q & ~sel) | (sel & {BUTTONS{lvl_i}});
								wake_q    <= 1'b0;
								state_q   <= ST_FLUSH;
							end else if (!pend_i) begin
								prev_q    <= (prev_q & ~sel) | (sel & {BUTTONS{set_i}});
								settled_q <= (settled_q & ~sel) | (sel & {BUTTONS{lvl_i}});
							end
						end
						if (is_tick) begin
							old_s1       <= settled_q;
							settle_s1    <= settle_b;
							settled_q    <= settled_q ^ restart_b;
							start_mode_q <= 1'b0;
							walk_q       <= '0;
							pair_q       <= 1'b0;
							state_q      <= ST_WALK;
						end
						if (is_suspend) begin
							prev_q <= pressed_b;
							wake_q <= 1'b1;
						end
						if (is_start) begin
							old_s1       <= pressed_b;
							settle_s1    <= '0;
							settled_q    <= pressed_b;
							start_mode_q <= 1'b1;
							walk_q       <= '0;
							pair_q       <= 1'b0;
							state_q      <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (walk_pair) begin
						pair_q <= 1'b1;
					end
					if (walk_report) begin
						reb_rep_q <= reboot_v;
						con_rep_q <= console_v;
					end
					if (walk_adv) begin
						pair_q <= 1'b0;
						if (walk_q == CW'(BUTTONS - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							walk_q <= walk_q + CW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (em_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mkd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.ev       (ev),
		.finish   (state_q == ST_FLUSH),
		.ready    (em_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ hw/rtl/mkd_lane.sv @@
// ----------------------------------------------------------------------------
// mkd_lane
// per-button countdown, pending flag and expiry decision
// ----------------------------------------------------------------------------
module mkd_lane #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mkd_pkg::lane_ctl_t     ctl,
	input  logic [COUNT_WIDTH-1:0] reload,
	input  logic                   level,
	input  logic                   settled,
	output logic                   pending,
	output logic                   restart,
	output logic                   settle
);
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   pending_q;
	logic                   expired;

	assign expired = pending_q && (count_q <= COUNT_WIDTH'(1));
	assign pending = pending_q;
	assign restart = ctl.tick && expired && (level != settled);
	assign settle  = ctl.tick && expired && (level == settled);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			count_q   <= '0;
		end else begin
			priority if (ctl.clear) begin
				pending_q <= 1'b0;
				count_q   <= '0;
			end else if (ctl.load) begin
				pending_q <= 1'b1;
				count_q   <= reload;
			end else begin
				if (ctl.tick && pending_q) begin
					priority if (!expired) begin
						count_q <= count_q - COUNT_WIDTH'(1);
					end else if (level != settled) begin
						count_q <= reload;
					end else begin
						pending_q <= 1'b0;
						count_q   <= '0;
					end
				end
			end
		end
	end

endmodule

@@ hw/rtl/mkd_emit.sv @@
// ----------------------------------------------------------------------------
// mkd_emit
// result holding stage: marks the final beat of an item, drops overflow
// ----------------------------------------------------------------------------
module mkd_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mkd_pkg::key_event_t ev,
	input  logic                finish,
	output logic                ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // key_button[2:0], key_pressed, reboot_notify,
	                                      // reboot_level, console_notify, console_level
	output logic                m_tlast
);
	import mkd_pkg::*;

	key_event_t             hold_q;
	key_event_t             out_q;
	logic                   hold_v_q;
	logic                   out_v_q;
	logic                   last_q;
	logic [RES_CNT_W-1:0]   count_q;
	logic                   out_free;
	logic                   take;
	logic                   do_push;
	logic                   do_finish;

	assign out_free  = !out_v_q || m_tready;
	assign ready     = !hold_v_q || out_free;
	assign take      = out_v_q && m_tready;
	assign do_push   = push && ready && (count_q < MAX_RESULTS);
	assign do_finish = finish && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			count_q  <= '0;
		end else begin
			if (take) begin
				out_v_q <= 1'b0;
			end
			if (do_push) begin
				hold_v_q <= 1'b1;
				count_q  <= count_q + RES_CNT_W'(1);
				if (hold_v_q) begin
					out_v_q <= 1'b1;
				end
			end else if (do_finish) begin
				hold_v_q <= 1'b0;
				count_q  <= '0;
				if (hold_v_q) begin
					out_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			hold_q <= ev;
			if (hold_v_q) begin
				out_q  <= hold_q;
				last_q <= 1'b0;
			end
		end else if (do_finish && hold_v_q) begin
			out_q  <= hold_q;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {out_q.console_level, out_q.console_notify, out_q.reboot_level,
		out_q.reboot_notify, out_q.key_pressed, out_q.key_button};

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-key debounce controller. Command beats are
// fed from a queue by a clocked driver, and an in-bench predictor computes the
// key events that each accepted beat causes. A clocked monitor checks every
// event beat against the oldest pending one. Registers are rewritten between
// phases while the block is idle. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mkd_pkg::*;

	localparam int NUM_KEYS    = 8;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		cmd_t       cmd;
		logic [2:0] button;
		logic [7:0] pins;
		logic       wake;
	} cmd_beat_t;

	typedef struct {
		logic [2:0] button;
		logic       pressed;
		logic       last;
		logic       reboot_ntf;
		logic       reboot_lvl;
		logic       console_ntf;
		logic       console_lvl;
	} key_event_exp_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata     = '0;
	logic [1:0]  s_tuser     = '0;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index   = '0;
	logic [15:0] cfg_data    = '0;

	multi_key_debounce_controller_top #(
		.BUTTONS     (NUM_KEYS),
		.COUNT_WIDTH (16)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [15:0] debounce_len;
	logic [7:0]  act_low;
	logic [7:0]  ignore_same;
	logic [7:0]  pair_same;
	logic [7:0]  reboot_sel;
	logic [7:0]  reboot_edge_sel;
	logic [7:0]  console_sel;

	// predictor copy of the key state
	logic [7:0]  settled;
	logic [7:0]  previous;
	logic [7:0]  pending;
	logic [15:0] down_cnt [NUM_KEYS];
	logic        wake_armed;
	logic        reboot_seen;
	logic        console_seen;

	cmd_beat_t      cmd_beats[$];
	key_event_exp_t beat_events[$];
	key_event_exp_t pending_key_events[$];

	int  errors      = 0;
	int  beats_sent  = 0;
	int  events_seen = 0;
	int  reg_writes  = 0;
	int  settings    = 0;
	int  cycles      = 0;
	int  send_gap    = 0;
	int  stall_left  = 0;
	bit  fast_mode   = 1'b0;
	logic [7:0] line_levels = '0;

	initial begin
		debounce_len    = 16'd5;
		act_low         = '0;
		ignore_same     = '0;
		pair_same       = '0;
		reboot_sel      = '0;
		reboot_edge_sel = '0;
		console_sel     = '0;
		settled         = '0;
		previous        = '0;
		pending         = '0;
		foreach (down_cnt[k]) down_cnt[k] = '0;
		wake_armed      = 1'b0;
		reboot_seen     = 1'b0;
		console_seen    = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		errors++;
		if (errors <= 30)
			$display("mismatch at cycle %0d: %s expected %0h got %0h", cycles, what,
				exp_v, got_v);
	endtask

	function automatic logic [15:0] reload_len();
		return (debounce_len == 16'd0) ? 16'd1 : debounce_len;
	endfunction

	function automatic void add_event(input int b, input logic lvl, input logic rn,
			input logic rl, input logic cn, input logic cl);
		key_event_exp_t ev;
		if (beat_events.size() >= 16)
			return;
		ev.button      = b[2:0];
		ev.pressed     = lvl;
		ev.last        = 1'b0;
		ev.reboot_ntf  = rn;
		ev.reboot_lvl  = rl;
		ev.console_ntf = cn;
		ev.console_lvl = cl;
		beat_events.push_back(ev);
	endfunction

	function automatic void settle_key(input int i);
		logic s;
		logic same;
		logic reboot;
		logic console;
		logic rn;
		logic cn;
		s       = settled[i];
		same    = (previous[i] == s);
		reboot  = 1'b1;
		console = 1'b1;
		if (same && ignore_same[i])
			return;
		if (same && pair_same[i])
			add_event(i, ~s, 1'b0, 1'b0, 1'b0, 1'b0);
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (reboot_sel[k]) begin
				if (reboot_edge_sel[k])
					reboot &= (settled[k] != previous[k]);
				else
					reboot &= settled[k];
			end
			if (console_sel[k])
				console &= settled[k];
		end
		rn           = reboot || (reboot_seen != reboot);
		reboot_seen  = reboot;
		cn           = (console_seen != console);
		console_seen = console;
		add_event(i, s, rn, reboot, cn, console);
	endfunction

	function automatic void debounce_step(input logic [1:0] user, input logic [15:0] data);
		cmd_t       cmd;
		logic [2:0] idx;
		logic [7:0] pins;
		logic       wake;
		logic       lvl;
		cmd  = cmd_t'(user);
		idx  = data[2:0];
		pins = data[10:3];
		wake = data[11];
		beat_events.delete();
		case (cmd)
			CMD_EDGE: begin
				if (wake && wake_armed) begin
					lvl = pins[idx] ^ act_low[idx];
					settled[idx] = lvl;
					add_event(idx, ~previous[idx], 1'b0, 1'b0, 1'b0, 1'b0);
					if (previous[idx] == lvl) begin
						down_cnt[idx] = reload_len();
						pending[idx]  = 1'b1;
					end
					wake_armed = 1'b0;
				end else if (pending[idx]) begin
					down_cnt[idx] = reload_len();
				end else begin
					previous[idx] = settled[idx];
					settled[idx]  = pins[idx] ^ act_low[idx];
					down_cnt[idx] = reload_len();
					pending[idx]  = 1'b1;
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < NUM_KEYS; i++) begin
					if (pending[i]) begin
						if (down_cnt[i] > 16'd1) begin
							down_cnt[i]--;
						end else begin
							lvl = pins[i] ^ act_low[i];
							if (lvl != settled[i]) begin
								settled[i]  = lvl;
								down_cnt[i] = reload_len();
							end else begin
								pending[i]  = 1'b0;
								down_cnt[i] = '0;
								settle_key(i);
							end
						end
					end
				end
			end
			CMD_SUSPEND: begin
				previous   = pins ^ act_low;
				wake_armed = 1'b1;
			end
			default: begin
				pending = '0;
				for (int i = 0; i < NUM_KEYS; i++) begin
					down_cnt[i] = '0;
					settled[i]  = pins[i] ^ act_low[i];
					add_event(i, settled[i], 1'b0, 1'b0, 1'b0, 1'b0);
				end
			end
		endcase
		if (beat_events.size() > 0)
			beat_events[beat_events.size()-1].last = 1'b1;
		foreach (beat_events[k])
			pending_key_events.push_back(beat_events[k]);
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_DEBOUNCE_TICKS: debounce_len    = data;
			REG_ACTIVE_LOW:     act_low         = data[7:0];
			REG_NOISE_IGNORE:   ignore_same     = data[7:0];
			REG_MISSING_PAIR:   pair_same       = data[7:0];
			REG_REBOOT:         reboot_sel      = data[7:0];
			REG_REBOOT_EDGE:    reboot_edge_sel = data[7:0];
			REG_CONSOLE:        console_sel     = data[7:0];
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (fast_mode || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// command beat driver
	always @(posedge clk) begin
		cmd_beat_t bt;
		logic      nxt_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				debounce_step(s_tuser, s_tdata);
				beats_sent++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_beats.size() > 0) begin
					bt = cmd_beats.pop_front();
					s_tdata   <= {4'b0000, bt.wake, bt.pins, bt.button};
					s_tuser   <= bt.cmd;
					nxt_valid = 1'b1;
					send_gap  = pick_gap();
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	// key event monitor
	always @(posedge clk) begin
		key_event_exp_t ev;
		int             n;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				events_seen++;
				if (pending_key_events.size() == 0) begin
					report_mismatch("unexpected event beat", 16'h0, {m_tlast, m_tdata});
				end else begin
					ev = pending_key_events.pop_front();
					if (m_tdata[2:0] != ev.button)
						report_mismatch("key_button", ev.button, m_tdata[2:0]);
					if (m_tdata[3] != ev.pressed)
						report_mismatch("key_pressed", ev.pressed, m_tdata[3]);
					if (m_tlast != ev.last)
						report_mismatch("is_last", ev.last, m_tlast);
					if (m_tdata[4] != ev.reboot_ntf)
						report_mismatch("reboot_notify", ev.reboot_ntf, m_tdata[4]);
					if (m_tdata[5] != ev.reboot_lvl)
						report_mismatch("reboot_level", ev.reboot_lvl, m_tdata[5]);
					if (m_tdata[6] != ev.console_ntf)
						report_mismatch("console_notify", ev.console_ntf, m_tdata[6]);
					if (m_tdata[7] != ev.console_lvl)
						report_mismatch("console_level", ev.console_lvl, m_tdata[7]);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				n = pick_gap();
				if (n == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready   <= 1'b0;
					stall_left = n - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic push_beat(input cmd_t cmd, input logic [2:0] b, input logic [7:0] pins,
			input logic wake);
		cmd_beat_t bt;
		bt.cmd    = cmd;
		bt.button = b;
		bt.pins   = pins;
		bt.wake   = wake;
		cmd_beats.push_back(bt);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		reg_writes++;
	endtask

	task automatic set_regs(input logic [15:0] deb, input logic [7:0] al, input logic [7:0] ign,
			input logic [7:0] pair, input logic [7:0] reb, input logic [7:0] rebe,
			input logic [7:0] con);
		write_reg(REG_DEBOUNCE_TICKS, deb);
		write_reg(REG_ACTIVE_LOW,     {8'($urandom_range(0, 255)), al});
		write_reg(REG_NOISE_IGNORE,   {8'($urandom_range(0, 255)), ign});
		write_reg(REG_MISSING_PAIR,   {8'($urandom_range(0, 255)), pair});
		write_reg(REG_REBOOT,         {8'($urandom_range(0, 255)), reb});
		write_reg(REG_REBOOT_EDGE,    {8'($urandom_range(0, 255)), rebe});
		write_reg(REG_CONSOLE,        {8'($urandom_range(0, 255)), con});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		while (cmd_beats.size() != 0 || s_tvalid || pending_key_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// mostly edges and ticks, with bounce, suspend/wake, start and noise
	task automatic gen_traffic(input int n);
		int         r;
		logic [2:0] b;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			b = 3'($urandom_range(0, 7));
			if (r < 40) begin
				if ($urandom_range(0, 4) != 0)
					line_levels[b] = ~line_levels[b];
				push_beat(CMD_EDGE, b, line_levels, $urandom_range(0, 3) == 0);
			end else if (r < 80) begin
				if ($urandom_range(0, 6) == 0)
					line_levels[$urandom_range(0, 7)] ^= 1'b1;
				push_beat(CMD_TICK, b, line_levels, 1'($urandom_range(0, 1)));
			end else if (r < 86) begin
				push_beat(CMD_SUSPEND, b, line_levels, 1'($urandom_range(0, 1)));
			end else if (r < 90) begin
				push_beat(CMD_START, b, line_levels, 1'($urandom_range(0, 1)));
			end else begin
				push_beat(cmd_t'($urandom_range(0, 3)), b, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: settle after five ticks, suspend and wake, back-to-back edges
		push_beat(CMD_START,   3'd0, 8'hA5, 1'b0);
		push_beat(CMD_EDGE,    3'd0, 8'hA4, 1'b0);
		repeat (5) push_beat(CMD_TICK, 3'd5, 8'hA4, 1'b1);
		push_beat(CMD_EDGE,    3'd1, 8'hA6, 1'b0);
		push_beat(CMD_EDGE,    3'd1, 8'hA6, 1'b1);
		push_beat(CMD_TICK,    3'd2, 8'hA4, 1'b0);
		push_beat(CMD_TICK,    3'd7, 8'hA4, 1'b0);
		push_beat(CMD_SUSPEND, 3'd0, 8'h0F, 1'b0);
		push_beat(CMD_EDGE,    3'd3, 8'h07, 1'b1);
		push_beat(CMD_EDGE,    3'd7, 8'h87, 1'b1);
		push_beat(CMD_START,   3'd7, 8'hFF, 1'b1);
		drain();

		// zero length, both noise modes on one key, pair mode, bounce
		write_reg(3'd7, 16'($urandom_range(0, 65535)));
		set_regs(16'd0, 8'hF0, 8'h0F, 8'h33, 8'h03, 8'h01, 8'h0C);
		push_beat(CMD_START, 3'd0, 8'h00, 1'b0);
		push_beat(CMD_EDGE,  3'd0, 8'h01, 1'b0);
		push_beat(CMD_TICK,  3'd0, 8'h01, 1'b0);
		push_beat(CMD_EDGE,  3'd0, 8'h01, 1'b0);
		push_beat(CMD_TICK,  3'd0, 8'h01, 1'b0);
		push_beat(CMD_EDGE,  3'd5, 8'h20, 1'b0);
		push_beat(CMD_TICK,  3'd0, 8'h00, 1'b0);
		push_beat(CMD_TICK,  3'd0, 8'h00, 1'b0);
		drain();

		line_levels = '0;
		for (int p = 0; p < 7; p++) begin
			fast_mode = (p == 4);
			case (p)
				0: set_regs(16'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				1: set_regs(16'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				2: set_regs(16'hFFFF, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
				3: set_regs(16'd0, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
				default: set_regs(16'($urandom_range(1, 4)), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			if (p == 2) begin
				gen_traffic(30);
				push_beat(CMD_START, 3'd0, line_levels, 1'b0);
			end else begin
				gen_traffic(60);
			end
			drain();
		end

		foreach (pending_key_events[k])
			report_mismatch("event never seen, button", pending_key_events[k].button, 16'h0);

		$display("covered %0d command beats and %0d key event beats", beats_sent, events_seen);
		$display("over %0d register settings (%0d writes), %0d mismatches", settings,
			reg_writes, errors);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_lane.sv
hw/rtl/mkd_emit.sv
hw/rtl/multi_key_debounce_controller_top.sv
verif/tb_top.sv
